// ===== design/mie_pkg.sv =====
// Shared widths and types for the modular inverse block.
// No dependencies; imported by mie_divstep and modular_inverse_ext_euclid.
`timescale 1ns / 1ps

package mie_pkg;

  localparam int FIELD_BITS = 31;
  localparam int COEF_BITS  = FIELD_BITS + 2;
  localparam int CNT_BITS   = $clog2(FIELD_BITS);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/mie_divstep.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Folds each quotient bit into the product mult * quotient (Horner form).
// Depends on mie_pkg.
`timescale 1ns / 1ps

module mie_divstep
  import mie_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [FIELD_BITS-1:0] dividend,
  input  logic [FIELD_BITS-1:0] divisor,
  input  logic [COEF_BITS-1:0]  mult,
  output div_stat_t             stat,
  output logic [FIELD_BITS-1:0] rem,
  output logic [COEF_BITS-1:0]  prod
);

  logic                  busy;
  logic                  done;
  logic [CNT_BITS-1:0]   cnt;
  logic [FIELD_BITS-1:0] dsh;
  logic [FIELD_BITS:0]   trial;
  logic [FIELD_BITS+1:0] diff;
  logic                  qbit;

  assign trial = {rem, dsh[FIELD_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign qbit  = ~diff[FIELD_BITS+1];

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(FIELD_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsh  <= dividend;
      prod <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff[FIELD_BITS-1:0] : trial[FIELD_BITS-1:0];
      dsh  <= {dsh[FIELD_BITS-2:0], 1'b0};
      prod <= {prod[COEF_BITS-2:0], 1'b0} + (qbit ? mult : '0);
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == '0) |=> done)
    else $error("divider missed its done pulse");

endmodule

// ===== design/modular_inverse_ext_euclid.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    modulus[30:0], value[30:0]
// out      out_valid / out_ready  inverse[30:0], has_inverse
// One item at a time; each Euclid round runs one division in the bit-serial divider.
// The number of Euclid rounds per item is at most about 46.
// Reset clears the sequencer, divider control and output valid.
// A result waiting on out_ready does not block the next input beat until the next finish.
// Depends on mie_pkg and mie_divstep.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid
  import mie_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FIELD_BITS-1:0] modulus,
  input  logic [FIELD_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FIELD_BITS-1:0] inverse,
  output logic                  has_inverse
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TEST = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state;
  logic [FIELD_BITS-1:0] m_r;
  logic                  vzero;
  logic [FIELD_BITS-1:0] xr;
  logic [FIELD_BITS-1:0] yr;
  logic [COEF_BITS-1:0]  xc;
  logic [COEF_BITS-1:0]  yc;

  div_stat_t             stat;
  logic [FIELD_BITS-1:0] rem;
  logic [COEF_BITS-1:0]  prod;
  logic                  div_start;
  logic [COEF_BITS-1:0]  fixed;
  logic                  slot_free;

  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_TEST) && (yr != '0);
  assign fixed     = xc[COEF_BITS-1] ? xc + {2'b00, m_r} : xc;
  assign slot_free = !out_valid || out_ready;

  mie_divstep u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (xr),
    .divisor  (yr),
    .mult     (yc),
    .stat     (stat),
    .rem      (rem),
    .prod     (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          state <= (yr == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (stat.done) begin
            state <= S_TEST;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      m_r   <= modulus;
      vzero <= (value == '0);
      xr    <= modulus;
      yr    <= value;
      xc    <= '0;
      yc    <= COEF_BITS'(1);
    end else if (state == S_DIV && stat.done) begin
      xr <= yr;
      yr <= rem;
      xc <= yc;
      yc <= xc - prod;
    end
    if (state == S_DONE && slot_free) begin
      inverse     <= vzero ? '0 : fixed[FIELD_BITS-1:0];
      has_inverse <= !vzero && (xr == FIELD_BITS'(1));
    end
  end

  a_div_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (stat.busy || stat.done))
    else $error("waiting on an idle divider");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == S_DIV))
    else $error("divider result outside the divide state");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the finish state");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for modular_inverse_ext_euclid: directed table, then random beats.
// Expected results come from fixed table values or from an extended-Euclid predictor in this file.
// Depends on mie_pkg and the design sources.
`timescale 1ns / 1ps

module tb_top
  import mie_pkg::*;
;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 5000;
  localparam int TAIL_CYCLES  = 1600;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam logic [FIELD_BITS-1:0] MOD_MAX = '1;

  typedef struct packed {
    logic [FIELD_BITS-1:0] inverse;
    logic                  has_inverse;
  } inv_result_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] modulus;
    logic [FIELD_BITS-1:0] value;
    logic                  fixed_exp;
    logic [FIELD_BITS-1:0] inverse;
    logic                  has_inverse;
  } inv_case_t;

  localparam int NUM_DIRECTED = 21;

  inv_case_t directed_cases [NUM_DIRECTED] = '{
    '{31'd1,          31'd0,          1'b1, 31'd0,          1'b0},
    '{31'd7,          31'd0,          1'b1, 31'd0,          1'b0},
    '{MOD_MAX,        31'd0,          1'b1, 31'd0,          1'b0},
    '{31'd1,          31'd1,          1'b1, 31'd1,          1'b1},
    '{31'd1,          31'd5,          1'b0, 31'd0,          1'b0},
    '{31'd1,          MOD_MAX,        1'b0, 31'd0,          1'b0},
    '{31'd7,          31'd3,          1'b1, 31'd5,          1'b1},
    '{31'd7,          31'd10,         1'b1, 31'd5,          1'b1},
    '{MOD_MAX,        31'd1,          1'b1, 31'd1,          1'b1},
    '{MOD_MAX,        MOD_MAX - 31'd1, 1'b1, 31'd2147483646, 1'b1},
    '{MOD_MAX,        MOD_MAX,        1'b0, 31'd0,          1'b0},
    '{31'd2,          31'd1,          1'b1, 31'd1,          1'b1},
    '{31'd6,          31'd4,          1'b0, 31'd0,          1'b0},
    '{31'd1836311903, 31'd1134903170, 1'b0, 31'd0,          1'b0},
    '{31'd1134903170, 31'd1836311903, 1'b0, 31'd0,          1'b0},
    '{31'd0,          31'd1,          1'b0, 31'd0,          1'b0},
    '{31'd0,          31'd6,          1'b0, 31'd0,          1'b0},
    '{31'd1073741824, 31'd3,          1'b0, 31'd0,          1'b0},
    '{31'd1073741824, 31'd6,          1'b0, 31'd0,          1'b0},
    '{31'd1431655765, 31'd715827882,  1'b0, 31'd0,          1'b0},
    '{31'd13,         MOD_MAX,        1'b0, 31'd0,          1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [FIELD_BITS-1:0] modulus;
  logic [FIELD_BITS-1:0] value;
  logic                  out_valid;
  logic                  out_ready;
  logic [FIELD_BITS-1:0] inverse;
  logic                  has_inverse;

  inv_result_t inv_expect [$];
  inv_result_t want;
  int          fail_count   = 0;
  int          results_done = 0;
  int          cycle_count  = 0;
  bit          steady       = 1'b0;
  bit          sink_held    = 1'b0;

  modular_inverse_ext_euclid dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .modulus     (modulus),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .inverse     (inverse),
    .has_inverse (has_inverse)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic inv_result_t mod_inverse_of(input logic [FIELD_BITS-1:0] m,
                                                 input logic [FIELD_BITS-1:0] v);
    logic [63:0] r_prev, r_cur, c_prev, c_cur, quo, r_next, c_next;
    inv_result_t res;
    r_prev = 64'(m);
    c_prev = 64'd0;
    r_cur  = 64'(v);
    c_cur  = 64'd1;
    while (r_cur != 64'd0) begin
      quo    = r_prev / r_cur;
      r_next = r_prev % r_cur;
      c_next = c_prev - c_cur * quo;
      r_prev = r_cur;
      c_prev = c_cur;
      r_cur  = r_next;
      c_cur  = c_next;
    end
    if (c_prev[63]) begin
      c_prev = c_prev + 64'(m);
    end
    res.inverse     = (v != '0) ? c_prev[FIELD_BITS-1:0] : '0;
    res.has_inverse = (v != '0) && (r_prev == 64'd1);
    return res;
  endfunction

  function automatic int idle_cycles();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 94) return int'($urandom_range(1, 5));
    return int'($urandom_range(20, 200));
  endfunction

  task automatic offer_beat(input logic [FIELD_BITS-1:0] m, input logic [FIELD_BITS-1:0] v,
                            input inv_result_t exp_res, input int gap);
    in_valid <= 1'b1;
    modulus  <= m;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    inv_expect = {inv_expect, exp_res};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (inv_expect.size() != 0);
  endtask

  initial begin : stimulus
    logic [FIELD_BITS-1:0] m, v;
    inv_result_t           exp_res;
    int                    r;
    in_valid <= 1'b0;
    modulus  <= '0;
    value    <= '0;
    rst      <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cases[k]) begin
      if (directed_cases[k].fixed_exp) begin
        exp_res.inverse     = directed_cases[k].inverse;
        exp_res.has_inverse = directed_cases[k].has_inverse;
      end else begin
        exp_res = mod_inverse_of(directed_cases[k].modulus, directed_cases[k].value);
      end
      offer_beat(directed_cases[k].modulus, directed_cases[k].value, exp_res, idle_cycles());
    end
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) drain();
      steady = (i >= 300 && i < 340);
      r = int'($urandom_range(0, 99));
      if (r < 10) m = FIELD_BITS'($urandom_range(1, 100));
      else if (r < 15) m = FIELD_BITS'(MOD_MAX - $urandom_range(0, 7));
      else if (r < 20) m = 31'd1 << $urandom_range(0, 30);
      else m = FIELD_BITS'($urandom_range(1, MOD_MAX));
      r = int'($urandom_range(0, 99));
      if (r < 5) v = '0;
      else if (r < 15) v = FIELD_BITS'(m + $urandom_range(0, 1000));
      else if (r < 25) v = FIELD_BITS'($urandom_range(1, 100));
      else v = FIELD_BITS'($urandom());
      offer_beat(m, v, mod_inverse_of(m, v), steady ? 0 : idle_cycles());
    end
    steady = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!sink_held && results_done >= 120) begin
        sink_held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = steady ? 0 : idle_cycles();
        out_ready <= (n == 0);
        repeat ((n == 0) ? 1 : n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (inv_expect.size() == 0) begin
        $error("unexpected result beat: inverse=%0d has_inverse=%0b", inverse, has_inverse);
        fail_count++;
      end else begin
        want = inv_expect.pop_front();
        if (inverse !== want.inverse) begin
          $error("inverse: expected %0d, actual %0d", want.inverse, inverse);
          fail_count++;
        end
        if (has_inverse !== want.has_inverse) begin
          $error("has_inverse: expected %0b, actual %0b", want.has_inverse, has_inverse);
          fail_count++;
        end
      end
      results_done++;
    end
  end

endmodule

// ===== modular_inverse_ext_euclid.f =====
design/mie_pkg.sv
design/mie_divstep.sv
design/modular_inverse_ext_euclid.sv
verif/tb_top.sv
